>>> design/epmix_pkg.sv
// Shared types and constants for the entropy pool rotate-xor mixer.
// Used by the pool controller, the output queue and the port checker.
// No dependencies.
`timescale 1ns / 1ps

package epmix_pkg;

    // input command codes carried in s_tuser[1:0]
    typedef enum logic [1:0] {
        OP_ENTROPY = 2'd0,
        OP_DRAIN   = 2'd1,
        OP_STOP    = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OP_W   = 2;

    // one result item on its way to the output port
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } out_item_t;

endpackage

>>> design/entropy_pool_rotate_xor_mixer.sv
// Entropy pool mixer: byte-wide ring pool with rotate-left-by-one and xor mixing.
// Slave stream: s_tdata = data_byte, s_tuser = {call_start, op}.
// Master stream: m_tdata = out_byte, m_tlast = last.
// Op 0 mixes the byte into the pool entry at the write index (collect mode) or,
// while forwarding, passes it straight to the master side with tlast set.
// Only the first POOL_DEPTH bytes after a call_start are mixed; later ones are dropped.
// Op 1 drains pool entries 0 to count-1 (tlast on the final one), clears the count
// and turns forwarding on. Op 2 turns forwarding off. Op 3 is ignored.
// A mixed byte is a read of the pool memory and then a write-back
// through its single write port. Passthrough, stop and empty drains stay in idle.
// A drain sends one byte per cycle from the memory read port while the output
// queue has room, and pauses while the master side stalls.
// A two-entry output queue sits before the master port, so a result waiting to be
// taken does not hold off the next input transfer; when it fills, s_tready drops.
// Reset: pool reads as all zeros (per-entry valid flags), counts and index cleared,
// collect mode, no results pending. No clearing pass is needed.
`timescale 1ns / 1ps

module entropy_pool_rotate_xor_mixer
    import epmix_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_tuser,   // [1:0] op, [2] call_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);

    localparam int unsigned IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(POOL_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(POOL_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MIX,
        S_DRAIN
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  write_index_reg, write_index_next;
    logic [CNT_W-1:0]  collected_reg, collected_next;
    logic [CNT_W-1:0]  taken_reg, taken_next;
    logic              forwarding_reg, forwarding_next;
    logic [BYTE_W-1:0] mix_byte_reg, mix_byte_next;
    logic [IDX_W-1:0]  drain_idx_reg, drain_idx_next;
    logic [IDX_W-1:0]  drain_end_reg, drain_end_next;

    logic [OP_W-1:0]   in_op;
    logic [BYTE_W-1:0] in_byte;
    logic              in_start;
    logic              accept;
    logic [CNT_W-1:0]  taken_eff;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_data;

    logic              fifo_full;
    logic              push;
    out_item_t         push_item;
    out_item_t         pop_item;

    // input field unpacking
    assign in_op    = s_tuser[1:0];
    assign in_start = s_tuser[2];
    assign in_byte  = s_tdata[7:0];

    assign s_tready  = (state_reg == S_IDLE) && !fifo_full;
    assign accept    = s_tvalid && s_tready;
    assign taken_eff = in_start ? '0 : taken_reg;

    // rotated entry xor new byte, written back in the cycle after the read
    assign wr_data = {rd_data[BYTE_W-2:0], rd_data[BYTE_W-1]} ^ mix_byte_reg;

    // command decode and sequencing
    always_comb
    begin
        state_next       = state_reg;
        write_index_next = write_index_reg;
        collected_next   = collected_reg;
        taken_next       = taken_reg;
        forwarding_next  = forwarding_reg;
        mix_byte_next    = mix_byte_reg;
        drain_idx_next   = drain_idx_reg;
        drain_end_next   = drain_end_reg;
        rd_en            = 1'b0;
        rd_addr          = write_index_reg;
        wr_en            = 1'b0;
        push             = 1'b0;
        push_item        = '{out_byte: in_byte, last: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_ENTROPY:
                        begin
                            taken_next = taken_eff;
                            if (forwarding_reg)
                            begin
                                push = 1'b1;
                            end
                            else if (taken_eff < DEPTH_CNT)
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = write_index_reg;
                                mix_byte_next = in_byte;
                                taken_next    = taken_eff + 1'b1;
                                state_next    = S_MIX;
                            end
                        end
                        OP_DRAIN:
                        begin
                            collected_next  = '0;
                            forwarding_next = 1'b1;
                            if (collected_reg != '0)
                            begin
                                rd_en          = 1'b1;
                                rd_addr        = '0;
                                drain_idx_next = '0;
                                drain_end_next = IDX_W'(collected_reg - 1'b1);
                                state_next     = S_DRAIN;
                            end
                        end
                        OP_STOP:
                        begin
                            forwarding_next = 1'b0;
                        end
                        default:
                        begin
                            // unused code, no effect
                        end
                    endcase
                end
            end
            S_MIX:
            begin
                wr_en            = 1'b1;
                write_index_next = (write_index_reg == LAST_IDX) ? '0
                                                                 : write_index_reg + 1'b1;
                if (collected_reg < DEPTH_CNT)
                begin
                    collected_next = collected_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            S_DRAIN:
            begin
                push_item = '{out_byte: rd_data, last: (drain_idx_reg == drain_end_reg)};
                if (!fifo_full)
                begin
                    push = 1'b1;
                    if (drain_idx_reg == drain_end_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = drain_idx_reg + 1'b1;
                        drain_idx_next = drain_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            write_index_reg <= '0;
            collected_reg   <= '0;
            taken_reg       <= '0;
            forwarding_reg  <= 1'b0;
            drain_idx_reg   <= '0;
            drain_end_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            write_index_reg <= write_index_next;
            collected_reg   <= collected_next;
            taken_reg       <= taken_next;
            forwarding_reg  <= forwarding_next;
            drain_idx_reg   <= drain_idx_next;
            drain_end_reg   <= drain_end_next;
        end
    end

    // held entropy byte for the write-back cycle
    always_ff @(posedge clk)
    begin
        mix_byte_reg <= mix_byte_next;
    end

    // pool memory
    epmix_pool_ram #(
        .DEPTH  (POOL_DEPTH),
        .ADDR_W (IDX_W)
    ) u_pool (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (write_index_reg),
        .wr_data (wr_data)
    );

    // result queue towards the master port
    epmix_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop_valid (m_tvalid),
        .pop_ready (m_tready),
        .pop_item  (pop_item)
    );

    assign m_tdata = pop_item.out_byte;
    assign m_tlast = pop_item.last;

endmodule

>>> design/epmix_pool_ram.sv
// Pool store: synchronous single-read, single-write memory, registered read port.
// Per-entry valid flops make unwritten entries read as zero after reset.
// Depends on epmix_pkg for the byte width.
`timescale 1ns / 1ps

module epmix_pool_ram
    import epmix_pkg::*;
#(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [BYTE_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [BYTE_W-1:0] wr_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [BYTE_W-1:0] rd_data_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // entry valid flags, cleared at reset so the pool reads as all zeros
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // registered read port, holds its value while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/epmix_out_fifo.sv
// Two-entry output queue that decouples the pool controller from the master port.
// A waiting result does not stop the next item from being taken.
// Depends on epmix_pkg for the result item type.
`timescale 1ns / 1ps

module epmix_out_fifo
    import epmix_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      full,
    output logic      pop_valid,
    input  logic      pop_ready,
    output out_item_t pop_item
);

    out_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop_item  = slot_reg[rd_ptr_reg];

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/epmix_checker.sv
// Port-level checks for the entropy pool mixer, attached to the top level by bind.
// Depends on epmix_pkg for the command codes.
`timescale 1ns / 1ps

module epmix_checker
    import epmix_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [2:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // a stalled result keeps its valid and its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // no result offered once reset has been applied
    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result offered during reset");

    // a stop or an unused command leaves the block ready for the next transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[1:0] == OP_STOP || s_tuser[1:0] == OP_UNUSED)
        |=> s_tready)
        else $error("not ready after stop command");

    // an accepted input transfer never leaves tvalid
    // dropping a result that was already waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && s_tvalid && s_tready |=> m_tvalid)
        else $error("waiting result lost on input transfer");

endmodule

bind entropy_pool_rotate_xor_mixer epmix_checker u_epmix_checker (.*);

>>> verif/tb_top.sv
// Self-checking bench for the entropy pool rotate-xor mixer: a directed table, then
// random call/drain/forward sequences checked against an in-bench pool predictor.
// Depends on design/epmix_pkg.sv and design/entropy_pool_rotate_xor_mixer.sv.
`timescale 1ns / 1ps

module tb_top;
    import epmix_pkg::*;

    localparam int unsigned POOL_DEPTH = 32;
    localparam int unsigned RAND_ITEMS = 280;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic [2:0] s_tuser  = 3'b000;  // [1:0] op, [2] call_start
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;

    entropy_pool_rotate_xor_mixer #(
        .POOL_DEPTH (POOL_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // predictor state, mirrors the pool after reset
    bit [7:0]    pool_img [POOL_DEPTH];
    int unsigned wr_ptr;
    int unsigned fill_cnt;
    int unsigned call_taken;
    bit          fwd_on;

    out_item_t   awaited_out [$];
    int          mismatches;
    int unsigned items_sent;
    int          hold_cycles;
    bit          calm;

    // directed stimulus, with the result typed in where it is obvious
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        bit         start;
        bit         typed;
        bit         has_out;
        logic [7:0] t_byte;
        bit         t_last;
    } dir_row_t;

    localparam int DIR_ROWS = 17;
    dir_row_t dir_tab [DIR_ROWS] = '{
        // drain of an empty pool: nothing out, forwarding on
        '{OP_DRAIN,   8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
        // call start while forwarding: passed through only
        '{OP_ENTROPY, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1},
        '{OP_ENTROPY, 8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1},
        // unused opcode while forwarding
        '{OP_UNUSED,  8'hA5, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
        // drain while forwarding: count already zero
        '{OP_DRAIN,   8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
        // stop with call_start set, then stop while collecting
        '{OP_STOP,    8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
        '{OP_STOP,    8'hFF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{OP_UNUSED,  8'h5A, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
        // one byte into a zero pool, then drain it back
        '{OP_ENTROPY, 8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
        '{OP_DRAIN,   8'h00, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1},
        '{OP_STOP,    8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
        // drain starts at entry 0, not at the write index
        '{OP_ENTROPY, 8'h80, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_ENTROPY, 8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_ENTROPY, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_DRAIN,   8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{OP_ENTROPY, 8'h3C, 1'b0, 1'b1, 1'b1, 8'h3C, 1'b1},
        '{OP_STOP,    8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}
    };

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // pool behaviour for one accepted transfer
    function automatic void pool_mix_step(input logic [1:0] op, input logic [7:0] data,
                                          input bit start, output out_item_t res[$]);
        res = {};
        case (op)
            OP_ENTROPY:
            begin
                if (start)
                    call_taken = 0;
                if (fwd_on)
                    res.push_back('{out_byte: data, last: 1'b1});
                else if (call_taken < POOL_DEPTH)
                begin
                    pool_img[wr_ptr] = {pool_img[wr_ptr][6:0], pool_img[wr_ptr][7]} ^ data;
                    wr_ptr = (wr_ptr == POOL_DEPTH - 1) ? 0 : wr_ptr + 1;
                    if (fill_cnt < POOL_DEPTH)
                        fill_cnt++;
                    call_taken++;
                end
            end
            OP_DRAIN:
            begin
                for (int unsigned i = 0; i < fill_cnt; i++)
                    res.push_back('{out_byte: pool_img[i], last: (i + 1 == fill_cnt)});
                fill_cnt = 0;
                fwd_on   = 1'b1;
            end
            OP_STOP:
                fwd_on = 1'b0;
            default:
                ;
        endcase
    endfunction

    // one input transfer with a random gap ahead of it
    task automatic xfer_item(input logic [1:0] op, input logic [7:0] data, input bit start,
                             input bit typed, input bit has_out, input logic [7:0] t_byte,
                             input bit t_last);
        out_item_t pred [$];
        while (!calm && $urandom_range(99) < 38)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= {start, op};
        do
            @(posedge clk);
        while (!s_tready);
        pool_mix_step(op, data, start, pred);
        if (typed)
        begin
            if (has_out)
                awaited_out.push_back('{out_byte: t_byte, last: t_last});
        end
        else
        begin
            foreach (pred[i])
                awaited_out.push_back(pred[i]);
        end
        items_sent++;
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] data, input bit start);
        xfer_item(op, data, start, 1'b0, 1'b0, 8'h00, 1'b0);
    endtask

    // a caller's buffer: call_start on the first byte only
    task automatic feed_call(input int len);
        for (int k = 0; k < len; k++)
            send_item(OP_ENTROPY, 8'($urandom), k == 0);
    endtask

    // sender idles until every expected result has come
    task automatic wait_all_out();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_out.size() != 0);
    endtask

    // stimulus
    initial
    begin
        int unsigned rand_base;
        int unsigned pick;
        int          len;
        logic [1:0]  op;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[r])
            xfer_item(dir_tab[r].op, dir_tab[r].data, dir_tab[r].start, dir_tab[r].typed,
                      dir_tab[r].has_out, dir_tab[r].t_byte, dir_tab[r].t_last);

        // over-long call: bytes past the per-call limit are dropped
        feed_call(36);
        send_item(OP_DRAIN, 8'h00, 1'b0);
        send_item(OP_STOP, 8'h00, 1'b0);
        // two calls past the pool size: count saturates, write index wraps
        feed_call(20);
        feed_call(20);
        send_item(OP_DRAIN, 8'h00, 1'b0);
        send_item(OP_STOP, 8'h00, 1'b0);
        wait_all_out();

        // receiver holds off through a full drain while passthrough bytes keep coming
        feed_call(32);
        hold_cycles = 300;
        send_item(OP_DRAIN, 8'($urandom), 1'b0);
        repeat (12) send_item(OP_ENTROPY, 8'($urandom), 1'($urandom_range(1)));
        send_item(OP_STOP, 8'($urandom), 1'b0);
        wait_all_out();

        // random part
        rand_base = items_sent;
        while (items_sent - rand_base < RAND_ITEMS)
        begin
            calm = (items_sent - rand_base >= 100) && (items_sent - rand_base < 180);
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                // well-formed: stop, one or more calls, drain, some passthrough
                send_item(OP_STOP, 8'($urandom), 1'($urandom_range(1)));
                repeat ($urandom_range(1, 3))
                begin
                    len = ($urandom_range(99) < 15) ? $urandom_range(30, 40)
                                                    : $urandom_range(1, 8);
                    feed_call(len);
                end
                send_item(OP_DRAIN, 8'($urandom), 1'($urandom_range(1)));
                repeat ($urandom_range(0, 4))
                    send_item(OP_ENTROPY, 8'($urandom), 1'($urandom_range(1)));
            end
            else if (pick < 85)
            begin
                // broken runs: bytes without a call start, stray drains and stops
                repeat ($urandom_range(1, 6))
                begin
                    op = ($urandom_range(3) == 0) ? 2'($urandom_range(1, 2)) : OP_ENTROPY;
                    send_item(op, 8'($urandom), 1'b0);
                end
            end
            else
            begin
                // noise over every opcode
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)));
            end
        end
        calm = 1'b0;

        wait_all_out();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && awaited_out.size() == 0)
            $display("** entropy_pool_rotate_xor_mixer: PASSED **");
        else
            $display("** entropy_pool_rotate_xor_mixer: FAILED **");
        $finish;
    end

    // result side: random stalls, a counted hold-off, field checks
    initial
    begin
        out_item_t want;
        @(posedge clk iff rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (awaited_out.size() == 0)
                begin
                    $error("unexpected transfer: out_byte %02h last %0b", m_tdata, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = awaited_out.pop_front();
                    if (m_tdata !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, actual %02h", want.out_byte, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 38);
        end
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("** entropy_pool_rotate_xor_mixer: FAILED **");
        $finish;
    end

endmodule
